[rtl/apfd_pkg.sv]
package apfd_pkg;

    localparam int unsigned HEADER_BYTES  = 7;
    localparam int unsigned CAPTURE_BYTES = 12;
    localparam int unsigned HDR_CNT_W     = $clog2(HEADER_BYTES);
    localparam int unsigned CAP_IDX_W     = $clog2(CAPTURE_BYTES);

    localparam logic [31:0] FRAME_LIMIT_RESET = 32'd131072;

    localparam logic [7:0]  FRAME_TYPE_METHOD = 8'd1;
    localparam logic [7:0]  FRAME_TYPE_HEADER = 8'd2;
    localparam logic [7:0]  FRAME_TYPE_BODY   = 8'd3;

    localparam logic [15:0] CLASS_BASIC    = 16'd60;
    localparam logic [15:0] METHOD_PUBLISH = 16'd40;

    localparam logic [31:0] MIN_METHOD_PAYLOAD = 32'd4;
    localparam logic [31:0] MIN_HEADER_PAYLOAD = 32'd12;

    typedef enum logic [2:0] {
        PH_METHOD_HDR = 3'd0,
        PH_METHOD_PAY = 3'd1,
        PH_CHDR_HDR   = 3'd2,
        PH_CHDR_PAY   = 3'd3,
        PH_BODY_HDR   = 3'd4,
        PH_BODY_PAY   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_TYPE   = 3'd1,
        ERR_BAD_METHOD = 3'd2,
        ERR_TOO_LARGE  = 3'd3,
        ERR_OVERRUN    = 3'd4,
        ERR_SHORT      = 3'd5
    } err_t;

    typedef struct packed {
        err_t       error_code;
        logic       message_last;
        logic       has_byte;
        logic [7:0] body_byte;
    } res_t;

endpackage

[rtl/apfd_parser.sv]
module apfd_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    stream_byte,
    input  logic          cfg_write,
    input  logic [31:0]   cfg_data,
    output logic          res_valid,
    output apfd_pkg::res_t res
);
    import apfd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]           pay_cnt_reg, pay_cnt_next;
    logic [63:0]           body_left_reg, body_left_next;
    logic [31:0]           limit_reg, limit_next;

    logic [7:0]            type_reg;
    logic [23:0]           size_sr_reg;
    logic [31:0]           frame_len_reg;
    logic [7:0]            cap_reg [CAPTURE_BYTES];

    logic                  hdr_phase;
    logic                  pay_phase;
    logic                  hdr_last;
    logic [31:0]           hdr_size;
    logic [7:0]            want_type;
    logic                  pay_more;
    logic                  pay_end;
    logic [15:0]           cap_class;
    logic [15:0]           cap_method;
    logic [63:0]           cap_body_size;
    err_t                  err;

    assign hdr_phase = phase_reg inside {PH_METHOD_HDR, PH_CHDR_HDR, PH_BODY_HDR};
    assign pay_phase = phase_reg inside {PH_METHOD_PAY, PH_CHDR_PAY, PH_BODY_PAY};
    assign hdr_last  = hdr_phase && (hdr_cnt_reg == HDR_CNT_W'(HEADER_BYTES - 1));
    assign hdr_size  = {size_sr_reg, stream_byte};
    assign pay_more  = pay_cnt_reg < frame_len_reg;
    assign pay_end   = pay_phase && !pay_more;

    assign cap_class     = {cap_reg[0], cap_reg[1]};
    assign cap_method    = {cap_reg[2], cap_reg[3]};
    assign cap_body_size = {cap_reg[4], cap_reg[5], cap_reg[6], cap_reg[7],
                            cap_reg[8], cap_reg[9], cap_reg[10], cap_reg[11]};

    always_comb
    begin
        unique case (phase_reg)
            PH_CHDR_HDR: want_type = FRAME_TYPE_HEADER;
            PH_BODY_HDR: want_type = FRAME_TYPE_BODY;
            default:     want_type = FRAME_TYPE_METHOD;
        endcase
    end

    // Header checks run when the seventh octet arrives; payload checks run on
    // the frame-end octet, with the length check ahead of the class check.
    always_comb
    begin
        err = ERR_NONE;
        if (hdr_last) begin
            if (type_reg != want_type)
                err = ERR_BAD_TYPE;
            else if (hdr_size > limit_reg)
                err = ERR_TOO_LARGE;
            else if (phase_reg == PH_BODY_HDR && {32'd0, hdr_size} > body_left_reg)
                err = ERR_OVERRUN;
        end else if (pay_end && phase_reg == PH_METHOD_PAY) begin
            if (frame_len_reg < MIN_METHOD_PAYLOAD)
                err = ERR_SHORT;
            else if (cap_class != CLASS_BASIC || cap_method != METHOD_PUBLISH)
                err = ERR_BAD_METHOD;
        end else if (pay_end && phase_reg == PH_CHDR_PAY) begin
            if (frame_len_reg < MIN_HEADER_PAYLOAD)
                err = ERR_SHORT;
            else if (cap_class != CLASS_BASIC)
                err = ERR_BAD_METHOD;
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (err != ERR_NONE) begin
            phase_next = PH_METHOD_HDR;
        end else begin
            unique case (phase_reg)
                PH_METHOD_HDR: if (hdr_last) phase_next = PH_METHOD_PAY;
                PH_CHDR_HDR:   if (hdr_last) phase_next = PH_CHDR_PAY;
                PH_BODY_HDR:   if (hdr_last) phase_next = PH_BODY_PAY;
                PH_METHOD_PAY: if (pay_end) phase_next = PH_CHDR_HDR;
                PH_CHDR_PAY:
                    if (pay_end)
                        phase_next = (cap_body_size == 64'd0) ? PH_METHOD_HDR : PH_BODY_HDR;
                PH_BODY_PAY:
                    if (pay_end)
                        phase_next = (body_left_reg == 64'd0) ? PH_METHOD_HDR : PH_BODY_HDR;
                default:       phase_next = PH_METHOD_HDR;
            endcase
        end
    end

    // Result and counters.
    always_comb
    begin
        res_valid        = 1'b0;
        res.error_code   = err;
        res.message_last = 1'b0;
        res.has_byte     = 1'b0;
        res.body_byte    = 8'd0;

        hdr_cnt_next   = (hdr_phase && !hdr_last) ? hdr_cnt_reg + 1'b1 : '0;
        pay_cnt_next   = (pay_phase && pay_more) ? pay_cnt_reg + 32'd1 : 32'd0;
        body_left_next = body_left_reg;

        if (err != ERR_NONE) begin
            res_valid      = 1'b1;
            body_left_next = 64'd0;
        end else if (phase_reg == PH_BODY_PAY && pay_more) begin
            res_valid        = 1'b1;
            res.has_byte     = 1'b1;
            res.body_byte    = stream_byte;
            res.message_last = (body_left_reg == 64'd1);
            body_left_next   = body_left_reg - 64'd1;
        end else if (pay_end && phase_reg == PH_CHDR_PAY) begin
            body_left_next = cap_body_size;
            if (cap_body_size == 64'd0) begin
                // An empty body still closes the message with one item.
                res_valid        = 1'b1;
                res.message_last = 1'b1;
            end
        end else if (!hdr_phase && !pay_phase) begin
            body_left_next = 64'd0;
        end
    end

    assign limit_next = cfg_write ? cfg_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_METHOD_HDR;
            hdr_cnt_reg   <= '0;
            pay_cnt_reg   <= 32'd0;
            body_left_reg <= 64'd0;
            limit_reg     <= FRAME_LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
            if (step) begin
                phase_reg     <= phase_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                pay_cnt_reg   <= pay_cnt_next;
                body_left_reg <= body_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            if (hdr_phase) begin
                size_sr_reg <= {size_sr_reg[15:0], stream_byte};
                if (hdr_cnt_reg == '0)
                    type_reg <= stream_byte;
            end
            if (hdr_last && err == ERR_NONE)
                frame_len_reg <= hdr_size;
            if (pay_phase && pay_more && pay_cnt_reg < 32'(CAPTURE_BYTES))
                cap_reg[pay_cnt_reg[CAP_IDX_W-1:0]] <= stream_byte;
        end
    end

    property p_err_restarts;
        @(posedge clk) disable iff (!rst_n)
        step && res_valid && res.error_code != ERR_NONE
            |=> phase_reg == PH_METHOD_HDR && hdr_cnt_reg == '0;
    endproperty
    a_err_restarts: assert property (p_err_restarts)
        else $error("parser did not restart after an error item");

    property p_last_drains;
        @(posedge clk) disable iff (!rst_n)
        step && res_valid && res.has_byte && res.message_last |=> body_left_reg == 64'd0;
    endproperty
    a_last_drains: assert property (p_last_drains)
        else $error("body count not drained on the last body item");

    property p_hdr_cnt_idle;
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_METHOD_PAY || phase_reg == PH_CHDR_PAY
            || phase_reg == PH_BODY_PAY) |-> hdr_cnt_reg == '0;
    endproperty
    a_hdr_cnt_idle: assert property (p_hdr_cnt_idle)
        else $error("header count left nonzero during a payload");

endmodule

[rtl/apfd_out_skid.sv]
module apfd_out_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  apfd_pkg::res_t push_data,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output apfd_pkg::res_t out_data
);
    import apfd_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    property p_skid_behind_out;
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg;
    endproperty
    a_skid_behind_out: assert property (p_skid_behind_out)
        else $error("skid entry held while the output register is empty");

    property p_skid_moves_up;
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> out_data_reg == $past(skid_data_reg) && !skid_valid_reg;
    endproperty
    a_skid_moves_up: assert property (p_skid_moves_up)
        else $error("skid entry not moved to the output register");

    property p_push_lands;
        @(posedge clk) disable iff (!rst_n)
        push && in_ready |=> out_valid_reg;
    endproperty
    a_push_lands: assert property (p_push_lands)
        else $error("pushed item lost");

endmodule

[rtl/amqp_publish_frame_deframer.sv]
// Publish deframer for an AMQP 0-9 byte stream.
// The slave stream (s_tvalid/s_tready/s_tdata) takes one octet per item.
// The block expects a basic.publish method frame, a content header frame and
// then body frames until the announced body size has arrived; channel and
// header properties are ignored and frame-end octets are skipped unchecked.
// Each body octet leaves on the master stream with tuser bit 0 set; the octet
// that completes the message carries tlast. An empty body gives one item
// with tlast set and no octet. A protocol error gives one item carrying the
// error code in tuser[3:1] and parsing restarts at a method frame header.
// Throughput is one octet per clock while s_tready is high. A result is
// registered into the output register, or into the skid register when the
// output register is full and not read; the parser itself adds no stage.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register; s_tready falls only once the skid register fills.
// The cfg channel writes the frame size limit and is always ready; write it
// only while the block is idle. Reset clears the parser to the method header,
// empties the output stage and sets the limit to 131072.
module amqp_publish_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // body_byte
    output logic [3:0]  m_tuser,   // has_byte, error_code[2:0]
    output logic        m_tlast,   // message_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // frame_size_limit
);
    import apfd_pkg::*;

    logic step;
    logic res_valid;
    res_t res;
    res_t out_item;

    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;

    apfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .stream_byte (s_tdata),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    apfd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = out_item.body_byte;
    assign m_tuser = {out_item.error_code, out_item.has_byte};
    assign m_tlast = out_item.message_last;

endmodule
